[design/prrtt_pkg.sv]
// Shared types and codes for the priority round-robin task table.
// No dependencies.
package prrtt_pkg;
    localparam logic [1:0] K_INSERTED = 2'd0;
    localparam logic [1:0] K_EVICTED  = 2'd1;
    localparam logic [1:0] K_FINISHED = 2'd2;
    localparam logic [1:0] K_RUN_DONE = 2'd3;
    localparam logic       CMD_INSERT = 1'b0;
    localparam logic       CMD_RUN    = 1'b1;
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] remain;
    } t_entry;
endpackage

[design/prrtt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module prrtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/priority_round_robin_task_table_core.sv]
// Priority round-robin task table: a sorted table held in one RAM, walked by a
// sequencer that shifts entries one at a time, with a read state and a write state
// for each. Depends on prrtt_pkg, prrtt_ram. A full table first reports the eviction
// of its last entry before the insert result. A run reports each finished task after
// moving the entries behind it down, then a run-done result. Each result waits for i_ready.
// Throughput: one transaction at a time; the next is accepted the cycle after the
// final result of the previous one is taken.
// Reset: count and current slot cleared; RAM contents are left undefined.
module priority_round_robin_task_table_core #(
    parameter int CAPACITY = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_task_id,
    input  logic [7:0]  i_task_priority,
    input  logic [15:0] i_task_time,
    input  logic [7:0]  i_step_count,
    input  logic [15:0] i_quantum,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_task_id,
    output logic [7:0]  o_out_priority,
    output logic [15:0] o_out_remaining,
    output logic [5:0]  o_held,
    output logic        o_last
);
    import prrtt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EVRD   = 4'd1;  // read last slot for eviction
    localparam logic [3:0] S_EVOUT  = 4'd2;
    localparam logic [3:0] S_SRD    = 4'd3;  // search: issue read
    localparam logic [3:0] S_SCMP   = 4'd4;  // search: compare
    localparam logic [3:0] S_SHRD   = 4'd5;  // shift up: read
    localparam logic [3:0] S_SHWR   = 4'd6;  // shift up: write
    localparam logic [3:0] S_INS    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;  // wait for result to drain
    localparam logic [3:0] S_RRD    = 4'd9;  // run: read current
    localparam logic [3:0] S_RCHG   = 4'd10; // run: charge
    localparam logic [3:0] S_RMRD   = 4'd11; // remove: read next
    localparam logic [3:0] S_RMWR   = 4'd12; // remove: write down
    localparam logic [3:0] S_RMDONE = 4'd13;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_held, n_held;
    logic [AW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_idx, n_idx;     // walking index
    logic [CW-1:0] r_pos, n_pos;     // insertion slot
    logic [7:0]    r_steps, n_steps;
    logic [3:0]    r_ret, n_ret;     // state after result drains
    t_entry        r_new, n_new;
    logic [15:0]   r_q, n_q;
    // result register
    logic          r_ov, n_ov;
    logic [1:0]    r_kind, n_kind;
    t_entry        r_res, n_res;
    logic [CW-1:0] r_rheld, n_rheld;
    logic          r_last, n_last;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;

    prrtt_ram #(.WIDTH($bits(t_entry)), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_kind = r_kind;
    assign o_out_task_id = r_res.id;
    assign o_out_priority = r_res.prio;
    assign o_out_remaining = r_res.remain;
    assign o_held = 6'(r_rheld);
    assign o_last = r_last;

    // Sequencer
    always_comb begin
        n_state = r_state; n_held = r_held; n_cur = r_cur; n_idx = r_idx;
        n_pos = r_pos; n_steps = r_steps; n_ret = r_ret;
        n_new = r_new; n_q = r_q;
        n_ov = r_ov; n_kind = r_kind; n_res = r_res; n_rheld = r_rheld;
        n_last = r_last;
        we = 1'b0; waddr = '0; wdata = rdata; raddr = '0;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_new = '{i_task_id, i_task_priority, i_task_time};
                    n_steps = i_step_count;
                    n_q = i_quantum;
                    if (i_command == CMD_INSERT) begin
                        n_state = (r_held >= CAP) ? S_EVRD : S_SRD;
                        n_idx = '0;
                    end else begin
                        n_state = S_RRD;
                    end
                end
            end
            S_EVRD: begin
                raddr = LAST;
                n_state = S_EVOUT;
            end
            S_EVOUT: begin
                n_held = CAP - 1'b1;
                if (r_cur >= LAST) n_cur = '0;
                n_ov = 1'b1; n_kind = K_EVICTED; n_res = rdata;
                n_rheld = CAP - 1'b1; n_last = 1'b0;
                n_idx = '0;
                n_ret = S_SRD; n_state = S_OUT;
            end
            S_SRD: begin
                raddr = r_idx[AW-1:0];
                if (r_idx >= r_held) begin
                    n_pos = r_held; n_idx = r_held; n_state = S_SHRD;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (rdata.prio < r_new.prio) begin
                    n_pos = r_idx; n_idx = r_held; n_state = S_SHRD;
                end else begin
                    n_idx = r_idx + 1'b1; n_state = S_SRD;
                end
            end
            S_SHRD: begin
                // r_idx is the destination; read r_idx-1
                raddr = AW'(r_idx - 1'b1);
                n_state = (r_idx > r_pos) ? S_SHWR : S_INS;
            end
            S_SHWR: begin
                we = 1'b1; waddr = r_idx[AW-1:0]; wdata = rdata;
                n_idx = r_idx - 1'b1; n_state = S_SHRD;
            end
            S_INS: begin
                we = 1'b1; waddr = r_pos[AW-1:0]; wdata = r_new;
                if (r_held == '0) n_cur = '0;
                else if (CW'(r_cur) >= r_pos) n_cur = r_cur + 1'b1;
                if (CW'(n_cur) >= r_held + 1'b1) n_cur = '0;
                n_held = r_held + 1'b1;
                n_ov = 1'b1; n_kind = K_INSERTED; n_res = r_new;
                n_rheld = r_held + 1'b1; n_last = 1'b1;
                n_ret = S_IDLE; n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_ready) n_state = r_ret;
            end
            S_RRD: begin
                if (r_steps == '0 || r_held == '0) begin
                    n_ov = 1'b1; n_kind = K_RUN_DONE; n_res = '0;
                    n_rheld = r_held; n_last = 1'b1;
                    n_ret = S_IDLE; n_state = S_OUT;
                end else begin
                    if (CW'(r_cur) >= r_held) n_cur = '0;
                    raddr = (CW'(r_cur) >= r_held) ? '0 : r_cur;
                    n_state = S_RCHG;
                end
            end
            S_RCHG: begin
                n_steps = r_steps - 1'b1;
                if (r_q == '0 || rdata.remain <= r_q) begin
                    n_res = '{rdata.id, rdata.prio, 16'd0};
                    n_idx = CW'(r_cur);
                    n_state = S_RMRD;
                end else begin
                    we = 1'b1; waddr = r_cur;
                    wdata = '{rdata.id, rdata.prio, rdata.remain - r_q};
                    n_cur = (CW'(r_cur) + 1'b1 >= r_held) ? '0 : AW'(r_cur + 1'b1);
                    n_state = S_RRD;
                end
            end
            S_RMRD: begin
                // r_idx is destination; read r_idx+1
                if (r_idx + 1'b1 < r_held) begin
                    raddr = AW'(r_idx + 1'b1); n_state = S_RMWR;
                end else begin
                    n_state = S_RMDONE;
                end
            end
            S_RMWR: begin
                we = 1'b1; waddr = r_idx[AW-1:0]; wdata = rdata;
                n_idx = r_idx + 1'b1; n_state = S_RMRD;
            end
            S_RMDONE: begin
                n_held = r_held - 1'b1;
                if (CW'(r_cur) >= r_held - 1'b1) n_cur = '0;
                n_ov = 1'b1; n_kind = K_FINISHED;
                n_rheld = r_held - 1'b1; n_last = 1'b0;
                n_ret = S_RRD; n_state = S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_held <= '0; r_cur <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_held <= n_held; r_cur <= n_cur; r_ov <= n_ov;
        end
        r_idx <= n_idx; r_pos <= n_pos; r_steps <= n_steps; r_ret <= n_ret;
        r_new <= n_new; r_q <= n_q; r_kind <= n_kind;
        r_res <= n_res; r_rheld <= n_rheld; r_last <= n_last;
    end

    // Count never exceeds the table size
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_held <= CAP)
        else $error("held count overflow");
    // Result held stable while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |=> r_ov && $stable(r_res))
        else $error("result dropped");
    // Insert results always report the count it left
    a_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS |=> r_held == r_rheld)
        else $error("insert count mismatch");
    // No RAM write while idle
    a_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !we)
        else $error("stray write");
endmodule
